@@ design/mwr_pkg.sv @@
// Shared types and constants for the Montgomery word reduction core.
package mwr_pkg;

    localparam int LimbW    = 64;
    localparam int MaxLimbs = 4;
    localparam int CfgIdxW  = 3;

    localparam logic [CfgIdxW-1:0] CFG_MOD0 = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MOD1 = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MOD2 = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MOD3 = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_INV  = 3'd4;

    typedef logic [LimbW-1:0] limb_t;

    // one queued entry between front and back: a limb and its role
    typedef struct packed {
        limb_t data;
        logic  last;
        logic  keep;   // limb goes into the value store
    } cmd_t;

endpackage

@@ design/mwr_front.sv @@
// Front end: accepts limbs, counts them and marks which ones are stored.
module mwr_front
    import mwr_pkg::*;
#(
    parameter int LIMBS = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  limb_t t_limb,
    input  logic  t_last,
    input  logic  t_valid,
    output logic  t_stall,
    output cmd_t  cmd,
    output logic  cmd_valid,
    input  logic  cmd_full
);

    localparam int CntW = $clog2(2*LIMBS+1);

    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic            take;

    assign t_stall   = cmd_full;
    assign take      = t_valid && !cmd_full;
    assign cmd_valid = take;
    assign cmd.data  = t_limb;
    assign cmd.last  = t_last;
    assign cmd.keep  = (cnt_reg < CntW'(2*LIMBS));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (take)
        begin
            if (t_last)
                cnt_next = '0;
            else if (cmd.keep)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

@@ design/mwr_queue.sv @@
// Short FIFO between the front end and the reduction engine.
module mwr_queue
    import mwr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t wr_data,
    input  logic wr_en,
    output logic full,
    output cmd_t rd_data,
    output logic rd_valid,
    input  logic rd_en
);

    cmd_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

@@ design/mwr_engine.sv @@
// Back end: value store, word-serial REDC on one multiplier, final subtract, output.
module mwr_engine
    import mwr_pkg::*;
#(
    parameter int LIMBS = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  logic  cmd_valid,
    output logic  cmd_pop,
    input  limb_t mod_limb [MaxLimbs],
    input  limb_t minv,
    output limb_t res_limb,
    output logic  res_last,
    output logic  res_valid,
    input  logic  res_stall
);

    localparam int TW    = 2*LIMBS + 1;
    localparam int TIW   = $clog2(TW);
    localparam int LW    = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam int LW1   = $clog2(LIMBS+1);
    localparam int HalfW = LimbW / 2;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_M    = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_PROP = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_SUB  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    limb_t            t_reg [TW];
    logic [TIW-1:0]   ld_reg;
    logic [2:0]       st_reg;
    logic [LW-1:0]    i_reg;
    logic [LW1-1:0]   j_reg;
    logic [TIW-1:0]   p_reg;
    limb_t            m_reg;
    logic [2*LimbW-1:0] prod_reg;
    logic [1:0]       mk_reg;
    limb_t            carry_reg;
    logic             ge_reg;
    logic             bor_reg;
    logic             out_v_reg;
    logic [LW-1:0]    oi_reg;
    limb_t            out_reg;
    logic             out_last_reg;

    logic [TIW-1:0]   idx;
    logic [LimbW:0]   s1;
    logic [LimbW:0]   s2;
    limb_t            mul_a;
    limb_t            mul_b;
    logic [HalfW-1:0] half_a;
    logic [HalfW-1:0] half_b;
    logic [LimbW-1:0] pp;
    logic [6:0]       pp_sh;
    logic [LimbW:0]   ps;
    logic [LimbW:0]   diff;
    limb_t            rj;
    limb_t            nj;

    assign cmd_pop   = cmd_valid && (st_reg == S_LOAD);
    assign res_limb  = out_reg;
    assign res_last  = out_last_reg;
    assign res_valid = out_v_reg;

    assign idx   = TIW'(i_reg) + TIW'(j_reg);
    assign mul_a = (st_reg == S_M) ? t_reg[TIW'(i_reg)] : m_reg;
    assign mul_b = (st_reg == S_M) ? minv : nj;
    assign s1    = {1'b0, t_reg[idx]} + {1'b0, prod_reg[LimbW-1:0]};
    assign s2    = {1'b0, s1[LimbW-1:0]} + {1'b0, carry_reg};
    assign ps    = {1'b0, t_reg[p_reg]} + {1'b0, carry_reg};
    assign rj    = t_reg[TIW'(LIMBS) + TIW'(j_reg)];
    assign nj    = mod_limb[j_reg[LW-1:0]];
    assign diff  = {1'b0, rj} - {1'b0, nj} - {{LimbW{1'b0}}, bor_reg};

    // 64x64 product accumulated in prod_reg from 32x32 partial products selected by mk_reg
    assign half_a = mk_reg[1] ? mul_a[LimbW-1:HalfW] : mul_a[HalfW-1:0];
    assign half_b = mk_reg[0] ? mul_b[LimbW-1:HalfW] : mul_b[HalfW-1:0];
    assign pp     = {{HalfW{1'b0}}, half_a} * {{HalfW{1'b0}}, half_b};
    assign pp_sh  = {({1'b0, mk_reg[1]} + {1'b0, mk_reg[0]}), 5'd0};

    always_ff @(posedge clk)
    begin
        if (st_reg == S_M || st_reg == S_MUL)
            prod_reg <= ((mk_reg == 2'd0) ? '0 : prod_reg)
                        + ({{LimbW{1'b0}}, pp} << pp_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_LOAD;
            ld_reg    <= '0;
            mk_reg    <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (out_v_reg && !res_stall && st_reg != S_OUT)
                out_v_reg <= 1'b0;
            unique case (st_reg)
                S_LOAD:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.keep)
                            t_reg[ld_reg] <= cmd.data;
                        if (cmd.keep && !cmd.last)
                            ld_reg <= ld_reg + 1'b1;
                        if (cmd.last)
                        begin
                            // zero the limbs that were never loaded
                            for (int k = 0; k < TW; k++)
                                if ((k >= int'(ld_reg) + (cmd.keep ? 1 : 0)))
                                    t_reg[k] <= '0;
                            ld_reg <= '0;
                            i_reg  <= '0;
                            st_reg <= S_M;
                        end
                    end
                end
                S_M:
                begin
                    mk_reg <= mk_reg + 1'b1;
                    if (mk_reg == 2'd3)
                    begin
                        st_reg <= S_ACC;
                        j_reg  <= LW1'(LIMBS);
                    end
                end
                S_ACC:
                begin
                    if (j_reg == LW1'(LIMBS))
                    begin
                        m_reg     <= prod_reg[LimbW-1:0];
                        j_reg     <= '0;
                        carry_reg <= '0;
                        st_reg    <= S_MUL;
                    end
                    else
                    begin
                        t_reg[idx] <= s2[LimbW-1:0];
                        carry_reg  <= prod_reg[2*LimbW-1:LimbW]
                                      + LimbW'(s1[LimbW]) + LimbW'(s2[LimbW]);
                        if (j_reg == LW1'(LIMBS-1))
                        begin
                            p_reg  <= TIW'(i_reg) + TIW'(LIMBS);
                            st_reg <= S_PROP;
                        end
                        else
                        begin
                            j_reg  <= j_reg + 1'b1;
                            st_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    mk_reg <= mk_reg + 1'b1;
                    if (mk_reg == 2'd3)
                        st_reg <= S_ACC;
                end
                S_PROP:
                begin
                    t_reg[p_reg] <= ps[LimbW-1:0];
                    carry_reg    <= LimbW'(ps[LimbW]);
                    if (p_reg == TIW'(TW-1))
                    begin
                        if (i_reg == LW'(LIMBS-1))
                        begin
                            j_reg  <= LW1'(LIMBS-1);
                            ge_reg <= 1'b1;
                            st_reg <= S_CMP;
                        end
                        else
                        begin
                            i_reg  <= i_reg + 1'b1;
                            st_reg <= S_M;
                        end
                    end
                    else
                        p_reg <= p_reg + 1'b1;
                end
                S_CMP:
                begin
                    // top limb nonzero means ge; else compare from the top down
                    if (t_reg[TW-1] == '0 && rj != nj)
                    begin
                        ge_reg  <= (rj > nj);
                        j_reg   <= '0;
                        bor_reg <= 1'b0;
                        st_reg  <= S_SUB;
                    end
                    else if (t_reg[TW-1] != '0 || j_reg == '0)
                    begin
                        j_reg   <= '0;
                        bor_reg <= 1'b0;
                        st_reg  <= S_SUB;
                    end
                    else
                        j_reg <= j_reg - 1'b1;
                end
                S_SUB:
                begin
                    if (ge_reg)
                    begin
                        t_reg[TIW'(LIMBS) + TIW'(j_reg)] <= diff[LimbW-1:0];
                        bor_reg <= diff[LimbW];
                    end
                    if (j_reg == LW1'(LIMBS-1))
                    begin
                        oi_reg <= '0;
                        st_reg <= S_OUT;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (!out_v_reg || !res_stall)
                    begin
                        out_v_reg    <= 1'b1;
                        out_reg      <= t_reg[TIW'(LIMBS) + TIW'(oi_reg)];
                        out_last_reg <= (oi_reg == LW'(LIMBS-1));
                        if (oi_reg == LW'(LIMBS-1))
                            st_reg <= S_LOAD;
                        else
                            oi_reg <= oi_reg + 1'b1;
                    end
                end
                default:
                    st_reg <= S_LOAD;
            endcase
        end
    end

endmodule

@@ design/montgomery_word_reduction_core.sv @@
// Top level: Montgomery word reduction core with config registers.
// Load: one limb per cycle while t_stall is low, into the store via a two-entry queue.
// Reduction: K rounds on one 32x32 multiplier, each 64x64 product built from four partial
// products; each round adds m*N and ripples the carry; then compare, subtract and output K limbs.
// The engine reduces one value at a time.
// rst_n (async, active low) restores modulus 1, inverse all ones, empty queue.
module montgomery_word_reduction_core
    import mwr_pkg::*;
#(
    parameter int LIMBS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LimbW-1:0]   t_limb,
    input  logic               t_last,
    input  logic               t_valid,
    output logic               t_stall,
    output logic [LimbW-1:0]   res_limb,
    output logic               res_last,
    output logic               res_valid,
    input  logic               res_stall,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [LimbW-1:0]   cfg_data
);

    limb_t mod_reg [MaxLimbs];
    limb_t inv_reg;
    cmd_t  f_cmd;
    cmd_t  q_cmd;
    logic  f_valid;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg[0] <= limb_t'(1);
            mod_reg[1] <= '0;
            mod_reg[2] <= '0;
            mod_reg[3] <= '0;
            inv_reg    <= '1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MOD0: mod_reg[0] <= cfg_data;
                CFG_MOD1: mod_reg[1] <= cfg_data;
                CFG_MOD2: mod_reg[2] <= cfg_data;
                CFG_MOD3: mod_reg[3] <= cfg_data;
                CFG_INV:  inv_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    mwr_front #(.LIMBS(LIMBS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .t_limb    (t_limb),
        .t_last    (t_last),
        .t_valid   (t_valid),
        .t_stall   (t_stall),
        .cmd       (f_cmd),
        .cmd_valid (f_valid),
        .cmd_full  (q_full)
    );

    mwr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (f_cmd),
        .wr_en    (f_valid),
        .full     (q_full),
        .rd_data  (q_cmd),
        .rd_valid (q_valid),
        .rd_en    (q_pop)
    );

    mwr_engine #(.LIMBS(LIMBS)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .mod_limb  (mod_reg),
        .minv      (inv_reg),
        .res_limb  (res_limb),
        .res_last  (res_last),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

endmodule

@@ design/mwr_checker.sv @@
// Port-level checker for the reduction core, bound to the top level.
module mwr_checker
    import mwr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             t_valid,
    input logic             t_stall,
    input logic             res_valid,
    input logic             res_stall,
    input logic             res_last,
    input logic [LimbW-1:0] res_limb
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_limb) && $stable(res_last))
        else $error("result changed while stalled");

    a_no_out_after_reset: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid right after reset");

    a_in_stall_reset: assert property (@(posedge clk)
        !rst_n |=> !t_stall)
        else $error("input stalled right after reset");

    a_input_known: assert property (@(posedge clk) disable iff (!rst_n)
        t_valid |-> !$isunknown(t_stall))
        else $error("stall unknown");

endmodule

bind montgomery_word_reduction_core mwr_checker u_mwr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .t_valid   (t_valid),
    .t_stall   (t_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_last  (res_last),
    .res_limb  (res_limb)
);
